// ===== sv/hrf_pkg.sv =====
`default_nettype none
package hrf_pkg;

  // Parser phases
  typedef enum logic [3:0] {
    PH_METHOD, PH_SP1, PH_URL, PH_SP2, PH_PROTO, PH_MAJOR, PH_DOT, PH_MINOR,
    PH_CR, PH_LF, PH_HEADER, PH_BODY, PH_DONE, PH_ERROR
  } phase_t;

  // Result event codes
  localparam logic [2:0] EV_URL   = 3'd0;
  localparam logic [2:0] EV_NAME  = 3'd1;
  localparam logic [2:0] EV_VALUE = 3'd2;
  localparam logic [2:0] EV_BODY  = 3'd3;
  localparam logic [2:0] EV_RLOK  = 3'd4;
  localparam logic [2:0] EV_HDONE = 3'd5;
  localparam logic [2:0] EV_MDONE = 3'd6;
  localparam logic [2:0] EV_ERROR = 3'd7;

  // Content-Length conversion states
  localparam logic [1:0] CV_START = 2'd0;
  localparam logic [1:0] CV_SIGN  = 2'd1;
  localparam logic [1:0] CV_DIG   = 2'd2;
  localparam logic [1:0] CV_STOP  = 2'd3;

  localparam int LEN_W = 50;
  localparam logic [3:0] CL_LEN  = 4'd14;
  localparam logic [3:0] MAX_DIG = 4'd15;
  localparam logic [3:0] IDX_SAT = 4'd7;
  localparam logic [3:0] PROTO_LEN = 4'd5;

  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_H     = 8'h48;

  // Result queue depth in result pairs
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  typedef struct packed {
    logic [2:0]       ev;
    logic [7:0]       data;
    logic [1:0]       meth;
    logic [3:0]       vmaj;
    logic [3:0]       vmin;
    logic [LEN_W-1:0] len;
    logic             last;
  } result_t;

  // Up to two results caused by one input beat
  typedef struct packed {
    logic [1:0] cnt;
    result_t    r1;
    result_t    r0;
  } pair_t;

  typedef struct packed {
    logic             colon;
    logic             seg;
    logic             line_any;
    logic             is_len;
    logic [3:0]       idx;
    logic [3:0]       dcnt;
    logic [1:0]       conv;
    logic [LEN_W-1:0] len;
  } hdr_t;

  typedef struct packed {
    hdr_t       st;
    logic       err;
    logic       emit;
    logic [2:0] ev;
  } hdr_out_t;

  function automatic logic [7:0] cl_char(input logic [3:0] i);
    logic [7:0] c;
    case (i)
      4'd0: c = "C";  4'd1: c = "o";  4'd2: c = "n";  4'd3: c = "t";
      4'd4: c = "e";  4'd5: c = "n";  4'd6: c = "t";  4'd7: c = "-";
      4'd8: c = "L";  4'd9: c = "e";  4'd10: c = "n"; 4'd11: c = "g";
      4'd12: c = "t"; 4'd13: c = "h";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] proto_char(input logic [3:0] i);
    logic [7:0] c;
    case (i)
      4'd0: c = "H"; 4'd1: c = "T"; 4'd2: c = "T"; 4'd3: c = "P"; 4'd4: c = "/";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [3:0] meth_len(input logic [1:0] k);
    logic [3:0] l;
    case (k)
      2'd0: l = 4'd3;
      2'd1: l = 4'd4;
      2'd2: l = 4'd3;
      default: l = 4'd6;
    endcase
    return l;
  endfunction

  function automatic logic [7:0] meth_char(input logic [1:0] k, input logic [3:0] i);
    logic [7:0] c;
    c = 8'h00;
    case (k)
      2'd0: case (i) 4'd0: c = "G"; 4'd1: c = "E"; 4'd2: c = "T"; default: c = 8'h00; endcase
      2'd1: case (i) 4'd0: c = "P"; 4'd1: c = "O"; 4'd2: c = "S"; 4'd3: c = "T";
              default: c = 8'h00; endcase
      2'd2: case (i) 4'd0: c = "P"; 4'd1: c = "U"; 4'd2: c = "T"; default: c = 8'h00; endcase
      default: case (i)
              4'd0: c = "D"; 4'd1: c = "E"; 4'd2: c = "L"; 4'd3: c = "E"; 4'd4: c = "T";
              4'd5: c = "E"; default: c = 8'h00; endcase
    endcase
    return c;
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  // One byte of a header line
  function automatic hdr_out_t hdr_byte(input hdr_t s, input logic [7:0] b);
    hdr_out_t o;
    logic [LEN_W-1:0] base;
    logic [7:0] d;
    o = '0;
    o.st = s;
    o.ev = EV_NAME;
    o.st.line_any = 1'b1;
    d = b - CH_ZERO;
    base = (s.conv == CV_DIG) ? s.len : '0;
    if (b == CH_COLON) begin
      if (s.colon) begin
        o.err = 1'b1;
      end else begin
        o.st.colon  = 1'b1;
        o.st.is_len = (s.idx == CL_LEN);
        o.st.seg    = 1'b0;
      end
    end else if (!s.seg && b == CH_SP) begin
      o.emit = 1'b0;
    end else begin
      o.st.seg = 1'b1;
      o.emit   = 1'b1;
      if (!s.colon) begin
        o.ev = EV_NAME;
        if (s.idx < CL_LEN && b == cl_char(s.idx)) o.st.idx = s.idx + 4'd1;
        else o.st.idx = CL_LEN + 4'd1;
      end else begin
        o.ev = EV_VALUE;
        if (s.is_len && s.conv != CV_STOP && s.dcnt < MAX_DIG) begin
          o.st.dcnt = s.dcnt + 4'd1;
          if (is_digit(b)) begin
            o.st.conv = CV_DIG;
            o.st.len  = {base[LEN_W-4:0], 3'b000} + {base[LEN_W-2:0], 1'b0}
                      + {{(LEN_W-4){1'b0}}, d[3:0]};
          end else if (b == CH_PLUS && s.conv == CV_START) begin
            o.st.conv = CV_SIGN;
          end else begin
            o.st.conv = CV_STOP;
          end
        end
      end
    end
    return o;
  endfunction

  function automatic pair_t add_res(input pair_t p, input result_t r);
    pair_t q;
    q = p;
    if (p.cnt == 2'd0) q.r0 = r;
    else q.r1 = r;
    q.cnt = p.cnt + 2'd1;
    return q;
  endfunction

  function automatic result_t mk_res(input logic [2:0] ev, input logic [7:0] data,
                                     input logic [1:0] meth, input logic [7:0] ver,
                                     input logic [LEN_W-1:0] len);
    result_t r;
    r.ev   = ev;
    r.data = data;
    r.meth = meth;
    r.vmaj = ver[7:4];
    r.vmin = ver[3:0];
    r.len  = len;
    r.last = 1'b0;
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/hrf_parser.sv =====
`default_nettype none
module hrf_parser (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           acc,
  input  wire logic [7:0]     byte_in,
  output hrf_pkg::pair_t      pair_o
);

  hrf_pkg::phase_t phase_r, phase_nxt;
  logic [3:0] mm_r, mm_nxt;
  logic [3:0] idx_r, idx_nxt;
  logic       held_r, held_nxt;
  logic [7:0] ver_r, ver_nxt;
  logic [1:0] meth_r, meth_nxt;
  logic [hrf_pkg::LEN_W-1:0] rem_r, rem_nxt;
  hrf_pkg::hdr_t hdr_r, hdr_nxt;

  hrf_pkg::pair_t   p;
  hrf_pkg::hdr_out_t h1, h2;
  hrf_pkg::hdr_t    hclr;
  logic [1:0] fk;
  logic       found;
  logic       ctl;
  logic       go_on;

  assign ctl = (byte_in == hrf_pkg::CH_CR) || (byte_in == hrf_pkg::CH_LF);

  // Per-beat decode: next state and up to two results
  always_comb begin
    phase_nxt = phase_r;
    mm_nxt    = mm_r;
    idx_nxt   = idx_r;
    held_nxt  = held_r;
    ver_nxt   = ver_r;
    meth_nxt  = meth_r;
    rem_nxt   = rem_r;
    hdr_nxt   = hdr_r;
    p         = '0;
    found     = 1'b0;
    fk        = 2'd0;
    go_on     = 1'b1;
    hclr      = hdr_r;
    hclr.line_any = 1'b0;
    hclr.colon    = 1'b0;
    hclr.seg      = 1'b0;
    hclr.idx      = 4'd0;
    hclr.is_len   = 1'b0;
    hclr.dcnt     = 4'd0;
    hclr.conv     = hrf_pkg::CV_START;
    h1 = hrf_pkg::hdr_byte(hdr_r, 8'h0D);
    h2 = hrf_pkg::hdr_byte(held_r ? h1.st : hdr_r, byte_in);
    unique case (phase_r)
      hrf_pkg::PH_METHOD: begin
        if (byte_in == hrf_pkg::CH_SP) begin
          for (int k = 3; k >= 0; k--) begin
            if (!mm_r[k] && hrf_pkg::meth_len(2'(k)) == idx_r) begin
              found = 1'b1;
              fk    = 2'(k);
            end
          end
          if (!found) begin
            phase_nxt = hrf_pkg::PH_ERROR;
            p = hrf_pkg::add_res(p, hrf_pkg::mk_res(hrf_pkg::EV_ERROR, 8'h00, meth_r,
                                                    ver_r, hdr_r.len));
          end else begin
            meth_nxt  = fk;
            idx_nxt   = 4'd0;
            phase_nxt = hrf_pkg::PH_SP1;
          end
        end else begin
          for (int k = 0; k < 4; k++) begin
            if (idx_r >= hrf_pkg::meth_len(2'(k)) ||
                byte_in != hrf_pkg::meth_char(2'(k), idx_r))
              mm_nxt[k] = 1'b1;
          end
          if (idx_r < hrf_pkg::IDX_SAT) idx_nxt = idx_r + 4'd1;
          if (mm_nxt == 4'hF) begin
            phase_nxt = hrf_pkg::PH_ERROR;
            p = hrf_pkg::add_res(p, hrf_pkg::mk_res(hrf_pkg::EV_ERROR, 8'h00, meth_r,
                                                    ver_r, hdr_r.len));
          end
        end
      end
      hrf_pkg::PH_SP1, hrf_pkg::PH_URL: begin
        if (ctl) begin
          phase_nxt = hrf_pkg::PH_ERROR;
          p = hrf_pkg::add_res(p, hrf_pkg::mk_res(hrf_pkg::EV_ERROR, 8'h00, meth_r,
                                                  ver_r, hdr_r.len));
        end else if (byte_in == hrf_pkg::CH_SP) begin
          if (phase_r == hrf_pkg::PH_URL) phase_nxt = hrf_pkg::PH_SP2;
        end else begin
          phase_nxt = hrf_pkg::PH_URL;
          p = hrf_pkg::add_res(p, hrf_pkg::mk_res(hrf_pkg::EV_URL, byte_in, meth_r,
                                                  ver_r, hdr_r.len));
        end
      end
      hrf_pkg::PH_SP2: begin
        if (byte_in == hrf_pkg::CH_H) begin
          idx_nxt   = 4'd1;
          phase_nxt = hrf_pkg::PH_PROTO;
        end else if (byte_in != hrf_pkg::CH_SP) begin
          phase_nxt = hrf_pkg::PH_ERROR;
          p = hrf_pkg::add_res(p, hrf_pkg::mk_res(hrf_pkg::EV_ERROR, 8'h00, meth_r,
                                                  ver_r, hdr_r.len));
        end
      end
      hrf_pkg::PH_PROTO: begin
        if (idx_r < hrf_pkg::PROTO_LEN && byte_in == hrf_pkg::proto_char(idx_r)) begin
          idx_nxt = idx_r + 4'd1;
          if (idx_r + 4'd1 == hrf_pkg::PROTO_LEN) begin
            idx_nxt   = 4'd0;
            phase_nxt = hrf_pkg::PH_MAJOR;
          end
        end else begin
          phase_nxt = hrf_pkg::PH_ERROR;
          p = hrf_pkg::add_res(p, hrf_pkg::mk_res(hrf_pkg::EV_ERROR, 8'h00, meth_r,
                                                  ver_r, hdr_r.len));
        end
      end
      hrf_pkg::PH_MAJOR, hrf_pkg::PH_MINOR: begin
        if (hrf_pkg::is_digit(byte_in)) begin
          if (phase_r == hrf_pkg::PH_MAJOR) begin
            ver_nxt   = {4'(byte_in - hrf_pkg::CH_ZERO), 4'h0};
            phase_nxt = hrf_pkg::PH_DOT;
          end else begin
            ver_nxt   = {ver_r[7:4], 4'(byte_in - hrf_pkg::CH_ZERO)};
            phase_nxt = hrf_pkg::PH_CR;
          end
        end else begin
          phase_nxt = hrf_pkg::PH_ERROR;
          p = hrf_pkg::add_res(p, hrf_pkg::mk_res(hrf_pkg::EV_ERROR, 8'h00, meth_r,
                                                  ver_r, hdr_r.len));
        end
      end
      hrf_pkg::PH_DOT, hrf_pkg::PH_CR: begin
        if ((phase_r == hrf_pkg::PH_DOT && byte_in == hrf_pkg::CH_DOT) ||
            (phase_r == hrf_pkg::PH_CR && byte_in == hrf_pkg::CH_CR)) begin
          phase_nxt = (phase_r == hrf_pkg::PH_DOT) ? hrf_pkg::PH_MINOR : hrf_pkg::PH_LF;
        end else begin
          phase_nxt = hrf_pkg::PH_ERROR;
          p = hrf_pkg::add_res(p, hrf_pkg::mk_res(hrf_pkg::EV_ERROR, 8'h00, meth_r,
                                                  ver_r, hdr_r.len));
        end
      end
      hrf_pkg::PH_LF: begin
        phase_nxt = hrf_pkg::PH_ERROR;
        if (byte_in == hrf_pkg::CH_LF) begin
          phase_nxt = hrf_pkg::PH_HEADER;
          hdr_nxt   = hclr;
          p = hrf_pkg::add_res(p, hrf_pkg::mk_res(hrf_pkg::EV_RLOK, 8'h00, meth_r,
                                                  ver_r, hdr_r.len));
        end else begin
          p = hrf_pkg::add_res(p, hrf_pkg::mk_res(hrf_pkg::EV_ERROR, 8'h00, meth_r,
                                                  ver_r, hdr_r.len));
        end
      end
      hrf_pkg::PH_HEADER: begin
        if (held_r) begin
          held_nxt = 1'b0;
          if (byte_in == hrf_pkg::CH_LF) begin
            go_on = 1'b0;
            // end of line
            if (!hdr_r.line_any) begin
              rem_nxt = hdr_r.len;
              p = hrf_pkg::add_res(p, hrf_pkg::mk_res(hrf_pkg::EV_HDONE, 8'h00, meth_r,
                                                      ver_r, hdr_r.len));
              if (hdr_r.len == '0) begin
                phase_nxt = hrf_pkg::PH_DONE;
                p = hrf_pkg::add_res(p, hrf_pkg::mk_res(hrf_pkg::EV_MDONE, 8'h00, meth_r,
                                                        ver_r, hdr_r.len));
              end else begin
                phase_nxt = hrf_pkg::PH_BODY;
              end
            end else if (!hdr_r.colon || !hdr_r.seg) begin
              phase_nxt = hrf_pkg::PH_ERROR;
              p = hrf_pkg::add_res(p, hrf_pkg::mk_res(hrf_pkg::EV_ERROR, 8'h00, meth_r,
                                                      ver_r, hdr_r.len));
            end else begin
              hdr_nxt = hclr;
            end
          end else begin
            // lone CR is a line byte
            hdr_nxt = h1.st;
            if (h1.err) begin
              go_on     = 1'b0;
              phase_nxt = hrf_pkg::PH_ERROR;
              p = hrf_pkg::add_res(p, hrf_pkg::mk_res(hrf_pkg::EV_ERROR, 8'h00, meth_r,
                                                      ver_r, hdr_r.len));
            end else if (h1.emit) begin
              p = hrf_pkg::add_res(p, hrf_pkg::mk_res(h1.ev, 8'h0D, meth_r,
                                                      ver_r, h1.st.len));
            end
          end
        end
        if (go_on) begin
          if (byte_in == hrf_pkg::CH_CR) begin
            held_nxt = 1'b1;
          end else begin
            hdr_nxt = h2.st;
            if (h2.err) begin
              hdr_nxt   = held_r ? h1.st : hdr_r;
              phase_nxt = hrf_pkg::PH_ERROR;
              p = hrf_pkg::add_res(p, hrf_pkg::mk_res(hrf_pkg::EV_ERROR, 8'h00, meth_r,
                                                      ver_r, hdr_nxt.len));
            end else if (h2.emit) begin
              p = hrf_pkg::add_res(p, hrf_pkg::mk_res(h2.ev, byte_in, meth_r,
                                                      ver_r, h2.st.len));
            end
          end
        end
      end
      hrf_pkg::PH_BODY: begin
        p = hrf_pkg::add_res(p, hrf_pkg::mk_res(hrf_pkg::EV_BODY, byte_in, meth_r,
                                                ver_r, hdr_r.len));
        if (rem_r != '0) rem_nxt = rem_r - (hrf_pkg::LEN_W)'(1);
        if (rem_nxt == '0) begin
          phase_nxt = hrf_pkg::PH_DONE;
          p = hrf_pkg::add_res(p, hrf_pkg::mk_res(hrf_pkg::EV_MDONE, 8'h00, meth_r,
                                                  ver_r, hdr_r.len));
        end
      end
      default: begin
        phase_nxt = phase_r;
      end
    endcase
    // mark the final result of the beat
    if (p.cnt == 2'd1) p.r0.last = 1'b1;
    else if (p.cnt == 2'd2) p.r1.last = 1'b1;
  end

  assign pair_o = p;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= hrf_pkg::PH_METHOD;
      mm_r    <= '0;
      idx_r   <= '0;
      held_r  <= 1'b0;
      ver_r   <= '0;
      meth_r  <= '0;
      rem_r   <= '0;
      hdr_r   <= '0;
    end else if (acc) begin
      phase_r <= phase_nxt;
      mm_r    <= mm_nxt;
      idx_r   <= idx_nxt;
      held_r  <= held_nxt;
      ver_r   <= ver_nxt;
      meth_r  <= meth_nxt;
      rem_r   <= rem_nxt;
      hdr_r   <= hdr_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sv/hrf_queue.sv =====
`default_nettype none
module hrf_queue (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     wr,
  input  wire hrf_pkg::pair_t wdata,
  input  wire logic     rd,
  output hrf_pkg::pair_t rdata,
  output logic          full,
  output logic          empty
);

  hrf_pkg::pair_t mem_r [hrf_pkg::QDEPTH];
  logic [hrf_pkg::QAW-1:0] wp_r, rp_r;
  logic [hrf_pkg::QAW:0]   cnt_r, cnt_nxt;

  assign full  = (cnt_r == (hrf_pkg::QAW+1)'(hrf_pkg::QDEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rp_r];

  // occupancy
  always_comb begin
    cnt_nxt = cnt_r;
    if (wr && !rd) cnt_nxt = cnt_r + (hrf_pkg::QAW+1)'(1);
    else if (rd && !wr) cnt_nxt = cnt_r - (hrf_pkg::QAW+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + (hrf_pkg::QAW)'(1);
      if (rd) rp_r <= rp_r + (hrf_pkg::QAW)'(1);
      cnt_r <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wdata;
  end

endmodule
`default_nettype wire

// ===== sv/hrf_unpack.sv =====
`default_nettype none
module hrf_unpack (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire hrf_pkg::pair_t head,
  input  wire logic      q_empty,
  output logic           q_rd,
  input  wire logic      pop,
  output hrf_pkg::result_t res
);

  logic sel_r, sel_nxt;
  logic last_of;
  logic take;

  // second slot is the last when present
  assign last_of = sel_r || (head.cnt == 2'd1);
  assign take    = pop && !q_empty;
  assign q_rd    = take && last_of;
  assign res     = sel_r ? head.r1 : head.r0;

  always_comb begin
    sel_nxt = sel_r;
    if (take) sel_nxt = !last_of;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) sel_r <= 1'b0;
    else sel_r <= sel_nxt;
  end

endmodule
`default_nettype wire

// ===== sv/http_request_framer.sv =====
// HTTP request framer.
// Input channel: one request byte per beat on in_byte_in, taken when push
// is high and full is low. Result channel: event beats with url, header
// name/value and body bytes plus progress events; the oldest result sits on
// the out_ ports while empty is low and is taken when pop is high.
// A byte's results are registered in the result queue when the byte is
// taken. Throughput: one byte per cycle while full is low; a byte yields
// zero to two results, and the result side drains one result per cycle
// while pop is high, so a stream of two-result bytes fills the four-entry
// result queue and full then rises. The decoder is combinational; the
// queue depth and the one-result-per-cycle drain set the sustained figure.
// out_last marks the final result caused by one input byte.
// Reset (rst_n low, synchronous) returns the parser to the start of a
// request and empties the result queue.
// A stalled receiver (pop low) holds the current result steady; bytes keep
// being taken until the queue fills.
`default_nettype none
module http_request_framer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  in_byte_in,
  output logic             empty,
  input  wire logic        pop,
  output logic [2:0]       out_event_res,
  output logic [7:0]       out_data_byte,
  output logic [1:0]       out_method_code,
  output logic [3:0]       out_version_major,
  output logic [3:0]       out_version_minor,
  output logic [49:0]      out_body_length,
  output logic             out_last
);

  hrf_pkg::pair_t   pair, head;
  hrf_pkg::result_t res;
  logic acc, q_rd, q_full, q_empty;

  assign acc   = push && !q_full;
  assign full  = q_full;
  assign empty = q_empty;

  // front: byte decoder
  hrf_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .byte_in (in_byte_in),
    .pair_o  (pair)
  );

  // result queue between front and back
  hrf_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (acc && (pair.cnt != 2'd0)),
    .wdata (pair),
    .rd    (q_rd),
    .rdata (head),
    .full  (q_full),
    .empty (q_empty)
  );

  // back: one result per beat
  hrf_unpack u_unpack (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (head),
    .q_empty (q_empty),
    .q_rd    (q_rd),
    .pop     (pop),
    .res     (res)
  );

  assign out_event_res     = res.ev;
  assign out_data_byte     = res.data;
  assign out_method_code   = res.meth;
  assign out_version_major = res.vmaj;
  assign out_version_minor = res.vmin;
  assign out_body_length   = res.len;
  assign out_last          = res.last;

endmodule
`default_nettype wire
